// File: rtl/assert_macros.svh
// Assertion macros shared by the bitfile header parser RTL.
// Included by name in any module that checks its own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bitfile header parser: property violated");
// A condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("bitfile header parser: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// File: rtl/fbhp_pkg.sv
// Types, constants and the preamble table of the bitfile header parser.
// Used by the result skid buffer and the top level; no dependencies.
package fbhp_pkg;

   // Header layout.
   localparam logic [3:0] PREAMBLE_LEN     = 4'd13;
   localparam logic [3:0] PREAMBLE_LAST    = 4'd12;
   localparam logic [3:0] FINAL_LAST_INDEX = 4'd4;
   localparam logic [2:0] HEADER_CHUNKS    = 3'd4;

   // Parser phases.
   typedef enum logic [2:0] {
      PH_PREAMBLE  = 3'd0,
      PH_CHUNK_HDR = 3'd1,
      PH_CHUNK_SKIP = 3'd2,
      PH_FINAL     = 3'd3,
      PH_PAYLOAD   = 3'd4,
      PH_MISMATCH  = 3'd5,
      PH_TRUNCATED = 3'd6,
      PH_ENDED     = 3'd7
   } phase_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_BUSY     = 3'd0,
      ST_DONE     = 3'd1,
      ST_PAYLOAD  = 3'd2,
      ST_MISMATCH = 3'd3,
      ST_TRUNC    = 3'd4,
      ST_END      = 3'd5
   } status_type;

   // Input transaction.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   // Result transaction.
   typedef struct packed {
      status_type  status;
      logic [31:0] config_length;
      logic [7:0]  payload_byte;
   } rsp_type;

   // Expected preamble byte at a given position.
   function automatic logic [7:0] preamble_byte(input logic [3:0] idx);
      logic [7:0] val;
      unique case (idx)
         4'd0:    val = 8'h00;
         4'd1:    val = 8'h09;
         4'd2:    val = 8'h0F;
         4'd3:    val = 8'hF0;
         4'd4:    val = 8'h0F;
         4'd5:    val = 8'hF0;
         4'd6:    val = 8'h0F;
         4'd7:    val = 8'hF0;
         4'd8:    val = 8'h0F;
         4'd9:    val = 8'hF0;
         4'd10:   val = 8'h00;
         4'd11:   val = 8'h00;
         4'd12:   val = 8'h01;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/fbhp_skid.sv
// Two-entry result buffer (output register plus skid register) for the parser.
// Depends on fbhp_pkg for the result transaction type.
module fbhp_skid import fbhp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    in_stall,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_data
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, skid_data_ff;
   logic    out_take, in_fire, load_out, load_skid, move_skid;

   assign out_take  = out_valid_ff & ~out_stall;
   assign in_fire   = in_valid & ~skid_valid_ff;
   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // Occupancy update: the skid entry drains into the output register first.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      load_out      = 1'b0;
      load_skid     = 1'b0;
      move_skid     = 1'b0;
      if (out_take) begin
         out_valid_in = 1'b0;
      end
      if (skid_valid_ff && out_take) begin
         move_skid     = 1'b1;
         out_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end
      if (in_fire) begin
         if (!out_valid_in) begin
            load_out     = 1'b1;
            out_valid_in = 1'b1;
         end else begin
            load_skid     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (move_skid) begin
         out_data_ff <= skid_data_ff;
      end else if (load_out) begin
         out_data_ff <= in_data;
      end
      if (load_skid) begin
         skid_data_ff <= in_data;
      end
   end

endmodule

// File: rtl/fpga_bitfile_header_parser_unit.sv
// Top level of the bitfile header parser: parsing state machine and result path.
// Depends on fbhp_pkg, fbhp_skid and assert_macros.svh.

// The parser takes one bitfile byte per transaction and answers every transaction
// with exactly one result. That result is on offer from the cycle after acceptance
// unless earlier results are still waiting for the receiver. A new byte can be
// accepted in every cycle: the phase, field index, chunk count, skip counter and
// length accumulator are computed combinationally and registered in the cycle of
// acceptance, and the result goes into a two-entry output buffer, so input is
// stalled only when both entries hold results that the receiver has not taken.
// Status reports header progress, the configuration length once the final
// length byte is seen, and each payload byte after that; a preamble mismatch,
// a truncated header or the end of the payload are sticky until reset.
module fpga_bitfile_header_parser_unit import fbhp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

`include "assert_macros.svh"

   phase_type   phase_ff, phase_in;
   logic [3:0]  field_index_ff, field_index_in;
   logic [2:0]  chunk_number_ff, chunk_number_in;
   logic [15:0] skip_remaining_ff, skip_remaining_in;
   logic [31:0] length_ff, length_in;
   logic [15:0] skip_dec;
   logic [2:0]  chunk_inc;
   logic        req_accept;
   rsp_type     result;

   assign req_accept = req_valid & ~req_stall;
   assign skip_dec   = skip_remaining_ff - 16'd1;
   assign chunk_inc  = chunk_number_ff + 3'd1;

   // Next state and result for the byte presented at the input.
   always_comb begin
      phase_in             = phase_ff;
      field_index_in       = field_index_ff;
      chunk_number_in      = chunk_number_ff;
      skip_remaining_in    = skip_remaining_ff;
      length_in            = length_ff;
      result.status        = ST_BUSY;
      result.config_length = 32'd0;
      result.payload_byte  = 8'd0;
      unique case (phase_ff)
         PH_MISMATCH: begin
            result.status = ST_MISMATCH;
         end
         PH_TRUNCATED: begin
            result.status = ST_TRUNC;
         end
         PH_ENDED: begin
            result.status        = ST_END;
            result.config_length = length_ff;
         end
         PH_PAYLOAD: begin
            result.config_length = length_ff;
            if (req_data.stream_end) begin
               phase_in      = PH_ENDED;
               result.status = ST_END;
            end else begin
               result.status       = ST_PAYLOAD;
               result.payload_byte = req_data.data_byte;
            end
         end
         default: begin
            if (req_data.stream_end) begin
               phase_in      = PH_TRUNCATED;
               result.status = ST_TRUNC;
            end else begin
               unique case (phase_ff)
                  PH_PREAMBLE: begin
                     if (field_index_ff >= PREAMBLE_LEN ||
                         preamble_byte(field_index_ff) != req_data.data_byte) begin
                        phase_in      = PH_MISMATCH;
                        result.status = ST_MISMATCH;
                     end else if (field_index_ff == PREAMBLE_LAST) begin
                        phase_in       = PH_CHUNK_HDR;
                        field_index_in = 4'd0;
                     end else begin
                        field_index_in = field_index_ff + 4'd1;
                     end
                  end
                  PH_CHUNK_HDR: begin
                     // Designator, then the big-endian 16-bit chunk length.
                     if (field_index_ff == 4'd0) begin
                        field_index_in = 4'd1;
                     end else if (field_index_ff == 4'd1) begin
                        skip_remaining_in = {req_data.data_byte, 8'd0};
                        field_index_in    = 4'd2;
                     end else begin
                        skip_remaining_in = {skip_remaining_ff[15:8], req_data.data_byte};
                        field_index_in    = 4'd0;
                        if (skip_remaining_in == 16'd0) begin
                           chunk_number_in = chunk_inc;
                           phase_in = (chunk_inc >= HEADER_CHUNKS) ? PH_FINAL : PH_CHUNK_HDR;
                        end else begin
                           phase_in = PH_CHUNK_SKIP;
                        end
                     end
                  end
                  PH_CHUNK_SKIP: begin
                     skip_remaining_in = skip_dec;
                     if (skip_dec == 16'd0) begin
                        chunk_number_in = chunk_inc;
                        field_index_in  = 4'd0;
                        phase_in = (chunk_inc >= HEADER_CHUNKS) ? PH_FINAL : PH_CHUNK_HDR;
                     end
                  end
                  default: begin
                     // Final chunk: designator, then the 32-bit big-endian length.
                     if (field_index_ff == 4'd0) begin
                        length_in      = 32'd0;
                        field_index_in = 4'd1;
                     end else begin
                        length_in = {length_ff[23:0], req_data.data_byte};
                        if (field_index_ff >= FINAL_LAST_INDEX) begin
                           field_index_in       = 4'd0;
                           phase_in             = PH_PAYLOAD;
                           result.status        = ST_DONE;
                           result.config_length = length_in;
                        end else begin
                           field_index_in = field_index_ff + 4'd1;
                        end
                     end
                  end
               endcase
            end
         end
      endcase
   end

   // Parser state advances only on an accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_PREAMBLE;
         field_index_ff    <= 4'd0;
         chunk_number_ff   <= 3'd0;
         skip_remaining_ff <= 16'd0;
         length_ff         <= 32'd0;
      end else if (req_accept) begin
         phase_ff          <= phase_in;
         field_index_ff    <= field_index_in;
         chunk_number_ff   <= chunk_number_in;
         skip_remaining_ff <= skip_remaining_in;
         length_ff         <= length_in;
      end
   end

   // Result buffer between the parser and the receiver.
   fbhp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (result),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   // The field index never runs past the preamble.
   `ASSERT_NEVER(a_preamble_index, clock, reset,
      phase_ff == PH_PREAMBLE && field_index_ff >= PREAMBLE_LEN)
   // A preamble mismatch is sticky.
   `ASSERT_PROP(a_mismatch_sticky, clock, reset,
      phase_ff == PH_MISMATCH |=> phase_ff == PH_MISMATCH)
   // No more than four header chunks are ever counted.
   `ASSERT_NEVER(a_chunk_count, clock, reset, chunk_number_ff > HEADER_CHUNKS)
   // The input is held off only while a result is on offer.
   `ASSERT_PROP(a_stall_needs_result, clock, reset, req_stall |-> rsp_valid)

endmodule

// File: verif/fpga_bitfile_header_parser_unit_test.sv
// Self-checking testbench for fpga_bitfile_header_parser_unit: feeds one bitfile stream and
// checks every result against a behavioural predictor of the header parser.
// Depends only on fbhp_pkg and the parser RTL.
`timescale 1ns / 1ps

module fpga_bitfile_header_parser_unit_test;
   import fbhp_pkg::*;

   // Header layout as the predictor sees it.
   localparam int          MAGIC_BYTES  = 13;
   localparam logic [103:0] HEADER_MAGIC =
      104'h00_09_0F_F0_0F_F0_0F_F0_0F_F0_00_00_01;
   localparam int          CHUNK_COUNT  = 4;
   localparam int          FINAL_BYTES  = 5;

   // How the single stream of the run is shaped; reset is applied only once.
   typedef enum logic [1:0] {
      RUN_CLEAN,
      RUN_BAD_PREAMBLE,
      RUN_CUT_SHORT
   } run_kind_type;

   // Result-side stall patterns.
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   fpga_bitfile_header_parser_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Predictor state, kept in step with every accepted transaction.
   phase_type   exp_phase        = PH_PREAMBLE;
   logic [3:0]  exp_field_index  = '0;
   logic [2:0]  exp_chunk_count  = '0;
   logic [15:0] exp_skip_left    = '0;
   logic [31:0] exp_config_len   = '0;
   rsp_type     expected_parse_results[$];

   // Stream plan and sender bookkeeping.
   run_kind_type run_kind;
   logic [15:0]  chunk_len[CHUNK_COUNT];
   logic [31:0]  planned_config_len;
   int           header_len;
   int           header_pos  = 0;
   int           fault_pos   = -1;
   int           burst_left  = 1;
   bit           valid_on    = 1'b0;
   int           fail_count  = 0;

   // Result-side stall generator.
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_span = 0;

   task automatic report_failure(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
   endtask

   // Works out the result of one accepted transaction and queues it.
   task automatic predict_parse_result(input req_type item);
      rsp_type res;
      res = '{status: ST_BUSY, config_length: 32'd0, payload_byte: 8'd0};
      case (exp_phase)
         PH_MISMATCH:  res.status = ST_MISMATCH;
         PH_TRUNCATED: res.status = ST_TRUNC;
         PH_ENDED: begin
            res.status = ST_END;
            res.config_length = exp_config_len;
         end
         PH_PAYLOAD: begin
            res.config_length = exp_config_len;
            if (item.stream_end) begin
               exp_phase = PH_ENDED;
               res.status = ST_END;
            end else begin
               res.status = ST_PAYLOAD;
               res.payload_byte = item.data_byte;
            end
         end
         default: begin
            if (item.stream_end) begin
               exp_phase = PH_TRUNCATED;
               res.status = ST_TRUNC;
            end else if (exp_phase == PH_PREAMBLE) begin
               if (exp_field_index >= MAGIC_BYTES ||
                   HEADER_MAGIC[8 * (MAGIC_BYTES - 1 - exp_field_index) +: 8]
                   != item.data_byte) begin
                  exp_phase = PH_MISMATCH;
                  res.status = ST_MISMATCH;
               end else if (exp_field_index == MAGIC_BYTES - 1) begin
                  exp_phase = PH_CHUNK_HDR;
                  exp_field_index = '0;
               end else begin
                  exp_field_index++;
               end
            end else if (exp_phase == PH_CHUNK_HDR || exp_phase == PH_CHUNK_SKIP) begin
               // Designator, two length bytes, then the bytes to skip.
               if (exp_phase == PH_CHUNK_SKIP) begin
                  exp_skip_left--;
               end else if (exp_field_index == 4'd0) begin
                  exp_field_index = 4'd1;
               end else if (exp_field_index == 4'd1) begin
                  exp_skip_left = {item.data_byte, 8'h00};
                  exp_field_index = 4'd2;
               end else begin
                  exp_skip_left = {exp_skip_left[15:8], item.data_byte};
                  exp_field_index = '0;
                  exp_phase = PH_CHUNK_SKIP;
               end
               if (exp_phase == PH_CHUNK_SKIP && exp_skip_left == 16'd0) begin
                  exp_chunk_count++;
                  exp_field_index = '0;
                  exp_phase = (exp_chunk_count >= CHUNK_COUNT) ? PH_FINAL : PH_CHUNK_HDR;
               end
            end else begin
               // Final chunk: designator, then the big-endian configuration length.
               if (exp_field_index == 4'd0) begin
                  exp_config_len = '0;
                  exp_field_index = 4'd1;
               end else begin
                  exp_config_len = {exp_config_len[23:0], item.data_byte};
                  if (exp_field_index == FINAL_BYTES - 1) begin
                     exp_field_index = '0;
                     exp_phase = PH_PAYLOAD;
                     res.status = ST_DONE;
                     res.config_length = exp_config_len;
                  end else begin
                     exp_field_index++;
                  end
               end
            end
         end
      endcase
      expected_parse_results.push_back(res);
   endtask

   // Sends one transaction and holds it until accepted; valid stays high within a burst.
   task automatic send_transaction(input logic [7:0] data, input logic last);
      req_type item;
      int      gap;
      item.data_byte  = data;
      item.stream_end = last;
      req_data <= item;
      if (!valid_on) begin
         req_valid <= 1'b1;
         valid_on = 1'b1;
      end
      do @(posedge clock); while (req_stall);
      predict_parse_result(item);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            valid_on = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // A header byte, replaced by the planned fault when its position comes up.
   task automatic send_header_byte(input logic [7:0] data);
      if (header_pos == fault_pos && run_kind == RUN_CUT_SHORT)
         send_transaction(8'($urandom_range(0, 255)), 1'b1);
      else if (header_pos == fault_pos && run_kind == RUN_BAD_PREAMBLE)
         send_transaction(data ^ 8'($urandom_range(1, 255)), 1'b0);
      else
         send_transaction(data, 1'b0);
      header_pos++;
   endtask

   // Pauses the sender until every queued result has been taken.
   task automatic wait_for_results();
      if (valid_on) begin
         req_valid <= 1'b0;
         valid_on = 1'b0;
      end
      do @(posedge clock); while (expected_parse_results.size() != 0);
   endtask

   task automatic test_preamble();
      for (int i = 0; i < MAGIC_BYTES; i++)
         send_header_byte(HEADER_MAGIC[8 * (MAGIC_BYTES - 1 - i) +: 8]);
   endtask

   // Four chunks with random designators; zero, short and long skips.
   task automatic test_header_chunks();
      for (int c = 0; c < CHUNK_COUNT; c++) begin
         send_header_byte(8'($urandom_range(0, 255)));
         send_header_byte(chunk_len[c][15:8]);
         send_header_byte(chunk_len[c][7:0]);
         for (int s = 0; s < chunk_len[c]; s++)
            send_header_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_final_length();
      send_header_byte(8'($urandom_range(0, 255)));
      for (int i = 3; i >= 0; i--)
         send_header_byte(planned_config_len[8 * i +: 8]);
   endtask

   // Payload bytes: the extremes first, then random, with one full drain midway.
   task automatic test_payload();
      int count;
      count = 470;
      send_transaction(8'h00, 1'b0);
      send_transaction(8'hFF, 1'b0);
      send_transaction(8'h55, 1'b0);
      send_transaction(8'hAA, 1'b0);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2)
            wait_for_results();
         send_transaction(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   // End of stream, then noise to show that the final status is sticky.
   task automatic test_stream_end();
      send_transaction(8'($urandom_range(0, 255)), 1'b1);
      send_transaction(8'hFF, 1'b0);
      send_transaction(8'h00, 1'b1);
      for (int i = 0; i < 30; i++)
         send_transaction(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   // Result stalls: the mode is redrawn at random whenever its span runs out.
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_span = $urandom_range(20, 120);
      end else begin
         stall_span--;
      end
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
         default:        rsp_stall <= ((stall_span % 8) < 3);
      endcase
   end

   // Compares each accepted result with the oldest expectation.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_parse_results.size() == 0) begin
            report_failure("result with nothing expected", 32'd0, 32'(rsp_data.status));
         end else begin
            want = expected_parse_results.pop_front();
            if (rsp_data.status !== want.status)
               report_failure("status", 32'(want.status), 32'(rsp_data.status));
            if (rsp_data.config_length !== want.config_length)
               report_failure("config_length", want.config_length, rsp_data.config_length);
            if (rsp_data.payload_byte !== want.payload_byte)
               report_failure("payload_byte", 32'(want.payload_byte),
                              32'(rsp_data.payload_byte));
         end
      end
   end

   initial begin
      // Plan the one stream of this run.
      case ($urandom_range(0, 4))
         0:       run_kind = RUN_BAD_PREAMBLE;
         1:       run_kind = RUN_CUT_SHORT;
         default: run_kind = RUN_CLEAN;
      endcase
      chunk_len[0] = 16'd0;
      chunk_len[1] = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 40));
      chunk_len[2] = 16'h0100 + 16'($urandom_range(0, 40));
      chunk_len[3] = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 40));
      case ($urandom_range(0, 3))
         0:       planned_config_len = 32'h0000_0000;
         1:       planned_config_len = 32'hFFFF_FFFF;
         default: planned_config_len = $urandom;
      endcase
      header_len = MAGIC_BYTES + FINAL_BYTES;
      for (int c = 0; c < CHUNK_COUNT; c++)
         header_len += 3 + chunk_len[c];
      if (run_kind == RUN_BAD_PREAMBLE)
         fault_pos = $urandom_range(0, MAGIC_BYTES - 1);
      else if (run_kind == RUN_CUT_SHORT)
         fault_pos = $urandom_range(0, 1) ? $urandom_range(0, header_len - 1)
                                          : header_len - $urandom_range(1, FINAL_BYTES);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_preamble();
      test_header_chunks();
      test_final_length();
      test_payload();
      test_stream_end();

      wait_for_results();
      repeat (8) @(posedge clock);
      if (expected_parse_results.size() != 0)
         report_failure("results never arrived", 32'd0, expected_parse_results.size());
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
